>>> hdl/lba_pkg.sv
// shared types, constants and helpers of the latching band alarm
package lba_pkg;

  localparam int TRIP_STEPS  = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int THRESH_BITS = 16;
  localparam int CMP_W       = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
  localparam int TIME_W      = 32;
  localparam int DUR_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // trip pattern length, held within the eight entries of the table
  localparam logic [3:0] TRIP_LEN =
    4'((TRIP_STEPS < 1) ? 1 : ((TRIP_STEPS > 8) ? 8 : TRIP_STEPS));

  localparam logic [TIME_W-1:0] CHIRP_MS     = 32'd50;
  localparam logic [TIME_W-1:0] CHIRP_PERIOD = 32'd5000;
  localparam logic [TIME_W-1:0] FLASH_PERIOD = 32'd250;

  localparam logic [DUR_W-1:0] TRIP_TABLE [8] = '{
    7'd70, 7'd60, 7'd70, 7'd60, 7'd70, 7'd60, 7'd70, 7'd60
  };

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_SAMPLE  = 2'd1,
    FUNC_DISMISS = 2'd2,
    FUNC_SPARE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_BREACH_HIGH  = 3'd1,
    EV_BREACH_LOW   = 3'd2,
    EV_BACK_IN_BAND = 3'd3,
    EV_DISMISSED    = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THRESHOLD = 2'd0,
    CFG_LOW_THRESHOLD  = 2'd1,
    CFG_HIGH_ENABLE    = 2'd2,
    CFG_LOW_ENABLE     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [THRESH_BITS-1:0] high_threshold;
    logic signed [THRESH_BITS-1:0] low_threshold;
    logic                          high_enable;
    logic                          low_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                    func;
    logic [TIME_W-1:0]             now_ms;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic               latched;
    logic               trip_high;
    logic signed [15:0] trip_value;
    logic [2:0]         event_res;
    logic               flash_on;
    logic               buzzer_on;
  } result_t;

  // wrapping signed difference: deadline reached when now - deadline >= 0
  function automatic logic due(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = now - deadline;
    return ~diff[TIME_W-1];
  endfunction

  function automatic logic [TIME_W-1:0] trip_dur(input logic [2:0] idx);
    return TIME_W'(TRIP_TABLE[idx]);
  endfunction

endpackage

>>> hdl/lba_in_if.sv
// input item channel of the latching band alarm
interface lba_in_if import lba_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [TIME_W-1:0]             now_ms;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output func, output now_ms, output sample, input ready);
  modport sink   (input valid, input func, input now_ms, input sample, output ready);
endinterface

>>> hdl/lba_out_if.sv
// result channel of the latching band alarm
interface lba_out_if import lba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               latched;
  logic               trip_high;
  logic signed [15:0] trip_value;
  logic [2:0]         event_res;
  logic               flash_on;
  logic               buzzer_on;

  modport source (output valid, output latched, output trip_high, output trip_value,
                  output event_res, output flash_on, output buzzer_on, input ready);
  modport sink   (input valid, input latched, input trip_high, input trip_value,
                  input event_res, input flash_on, input buzzer_on, output ready);
endinterface

>>> hdl/lba_cfg_regs.sv
// configuration register file of the latching band alarm
module lba_cfg_regs import lba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold <= 16'sh7FFF;
      cfg.low_threshold  <= 16'sh8000;
      cfg.high_enable    <= 1'b0;
      cfg.low_enable     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data[THRESH_BITS-1:0];
        CFG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data[THRESH_BITS-1:0];
        CFG_HIGH_ENABLE:    cfg.high_enable    <= cfg_data[0];
        CFG_LOW_ENABLE:     cfg.low_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/lba_alarm.sv
// alarm state, flash and chirp timers, buzzer pattern player and result logic
module lba_alarm import lba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic              latch, latch_next;
  logic              tripped_high, tripped_high_next;
  logic [15:0]       tripped_value, tripped_value_next;
  logic              inside_band, inside_band_next;
  logic              flash_phase, flash_phase_next;
  logic [TIME_W-1:0] flash_deadline, flash_deadline_next;
  logic [TIME_W-1:0] chirp_deadline, chirp_deadline_next;
  logic              pattern_active, pattern_active_next;
  logic              pattern_is_chirp, pattern_is_chirp_next;
  logic [2:0]        pattern_step, pattern_step_next;
  logic [TIME_W-1:0] step_deadline, step_deadline_next;
  logic              drive_level, drive_level_next;
  logic [2:0]        ev;

  logic [3:0]              step_inc;
  logic [3:0]              pattern_len;
  logic signed [CMP_W-1:0] s_ext, hi_ext, lo_ext;
  logic                    over, under, breach;
  logic [TIME_W-1:0]       now;

  assign now         = item.now_ms;
  assign step_inc    = {1'b0, pattern_step} + 4'd1;
  assign pattern_len = pattern_is_chirp ? 4'd1 : TRIP_LEN;
  assign s_ext       = CMP_W'(item.sample);
  assign hi_ext      = CMP_W'(cfg.high_threshold);
  assign lo_ext      = CMP_W'(cfg.low_threshold);
  assign over        = cfg.high_enable && (s_ext > hi_ext);
  assign under       = cfg.low_enable && (s_ext < lo_ext);
  assign breach      = over || under;

  always_comb begin
    latch_next            = latch;
    tripped_high_next     = tripped_high;
    tripped_value_next    = tripped_value;
    inside_band_next      = inside_band;
    flash_phase_next      = flash_phase;
    flash_deadline_next   = flash_deadline;
    chirp_deadline_next   = chirp_deadline;
    pattern_active_next   = pattern_active;
    pattern_is_chirp_next = pattern_is_chirp;
    pattern_step_next     = pattern_step;
    step_deadline_next    = step_deadline;
    drive_level_next      = drive_level;
    ev                    = EV_NONE;

    if (item.func == FUNC_DISMISS) begin
      if (latch) begin
        latch_next          = 1'b0;
        flash_phase_next    = 1'b0;
        pattern_active_next = 1'b0;
        drive_level_next    = 1'b0;
        ev                  = EV_DISMISSED;
      end
    end else begin
      // player advances first
      if (pattern_active && due(now, step_deadline)) begin
        if (step_inc >= pattern_len) begin
          pattern_active_next = 1'b0;
          drive_level_next    = 1'b0;
        end else begin
          pattern_step_next  = step_inc[2:0];
          drive_level_next   = ~step_inc[0];
          step_deadline_next = now + (pattern_is_chirp ? CHIRP_MS : trip_dur(step_inc[2:0]));
        end
      end
      if (latch) begin
        if (due(now, flash_deadline)) begin
          flash_deadline_next = now + FLASH_PERIOD;
          flash_phase_next    = ~flash_phase;
        end
        // a due chirp abandons whatever pattern is playing
        if (due(now, chirp_deadline)) begin
          chirp_deadline_next   = now + CHIRP_PERIOD;
          pattern_active_next   = 1'b1;
          pattern_is_chirp_next = 1'b1;
          pattern_step_next     = 3'd0;
          drive_level_next      = 1'b1;
          step_deadline_next    = now + CHIRP_MS;
        end
      end
      if (item.func == FUNC_SAMPLE) begin
        if (breach && !latch) begin
          latch_next            = 1'b1;
          tripped_high_next     = over;
          tripped_value_next    = s_ext[15:0];
          inside_band_next      = 1'b0;
          flash_phase_next      = 1'b1;
          flash_deadline_next   = now + FLASH_PERIOD;
          chirp_deadline_next   = now + CHIRP_PERIOD;
          pattern_active_next   = 1'b1;
          pattern_is_chirp_next = 1'b0;
          pattern_step_next     = 3'd0;
          drive_level_next      = 1'b1;
          step_deadline_next    = now + trip_dur(3'd0);
          ev                    = over ? EV_BREACH_HIGH : EV_BREACH_LOW;
        end else if (breach) begin
          inside_band_next = 1'b0;
        end else if (!inside_band) begin
          inside_band_next = 1'b1;
          ev               = EV_BACK_IN_BAND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch            <= 1'b0;
      tripped_high     <= 1'b0;
      tripped_value    <= 16'd0;
      inside_band      <= 1'b1;
      flash_phase      <= 1'b0;
      flash_deadline   <= '0;
      chirp_deadline   <= '0;
      pattern_active   <= 1'b0;
      pattern_is_chirp <= 1'b0;
      pattern_step     <= 3'd0;
      step_deadline    <= '0;
      drive_level      <= 1'b0;
    end else if (step) begin
      latch            <= latch_next;
      tripped_high     <= tripped_high_next;
      tripped_value    <= tripped_value_next;
      inside_band      <= inside_band_next;
      flash_phase      <= flash_phase_next;
      flash_deadline   <= flash_deadline_next;
      chirp_deadline   <= chirp_deadline_next;
      pattern_active   <= pattern_active_next;
      pattern_is_chirp <= pattern_is_chirp_next;
      pattern_step     <= pattern_step_next;
      step_deadline    <= step_deadline_next;
      drive_level      <= drive_level_next;
    end
  end

  assign res.latched    = latch_next;
  assign res.trip_high  = tripped_high_next;
  assign res.trip_value = tripped_value_next;
  assign res.event_res  = ev;
  assign res.flash_on   = flash_phase_next;
  assign res.buzzer_on  = drive_level_next;

endmodule

>>> hdl/latching_band_alarm_unit.sv
// Latching band alarm: window comparator with latch, flash timer and buzzer player.
// Items enter on the valid/ready channel "items": func selects tick, tick with sample
// or dismiss; now_ms is the wrapping millisecond time stamp. Each item gives exactly
// one result transaction on "results": latch, last trip direction and value, event
// code, flash phase and buzzer level after that item.
// Thresholds and arm bits are written through cfg_we/cfg_index/cfg_data, one register
// per cycle, by the user only while no item is in flight; the block has no check for it.
// Each accepted item waits in the input register until it can advance; the alarm state
// then updates in the same cycle as the item moves from the input register into the
// result register. Throughput is one item per cycle while the receiver is ready.
// When the receiver stalls, the result register holds and the input register still
// takes one more transaction; ready drops only when both are full.
// Synchronous reset empties both registers, clears the alarm state (inside band set)
// and restores the thresholds to their full-scale values with both edges disarmed.
module latching_band_alarm_unit import lba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lba_in_if.sink                items,
  lba_out_if.source             results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    advance;
  result_t res;
  result_t res_q;
  logic    out_valid;

  lba_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lba_alarm u_alarm (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  assign advance     = in_valid_q && (!out_valid || results.ready);
  assign items.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (items.ready) begin
      in_valid_q <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      item_q.func   <= items.func;
      item_q.now_ms <= items.now_ms;
      item_q.sample <= items.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign results.valid      = out_valid;
  assign results.latched    = res_q.latched;
  assign results.trip_high  = res_q.trip_high;
  assign results.trip_value = res_q.trip_value;
  assign results.event_res  = res_q.event_res;
  assign results.flash_on   = res_q.flash_on;
  assign results.buzzer_on  = res_q.buzzer_on;

endmodule

>>> test/latching_band_alarm_unit_test.sv
// self-checking testbench of the latching band alarm: directed table, random items, scoreboard
module latching_band_alarm_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lba_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 250;
  localparam int PHASES        = 6;
  localparam int TAIL_ITEMS    = 200;
  localparam int LONG_HOLD     = 60;
  localparam int TRIP_BEEPS    = TRIP_STEPS;

  localparam logic [31:0] CHIRP_LEN_MS   = 32'd50;
  localparam logic [31:0] CHIRP_EVERY_MS = 32'd5000;
  localparam logic [31:0] FLASH_EVERY_MS = 32'd250;
  localparam logic [31:0] BEEP_MS [8]    = '{70, 60, 70, 60, 70, 60, 70, 60};

  typedef struct {
    bit                 is_write;
    cfg_index_t         reg_sel;
    logic [15:0]        wdata;
    func_t              func;
    logic [31:0]        now_ms;
    logic signed [15:0] sample;
    bit                 typed;
    result_t            want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lba_in_if  item_bus ();
  lba_out_if result_bus ();

  latching_band_alarm_unit dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_bus),
    .results   (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // alarm state as the block should hold it
  logic signed [15:0] hi_thr = 16'sh7FFF;
  logic signed [15:0] lo_thr = 16'sh8000;
  bit                 hi_arm = 1'b0;
  bit                 lo_arm = 1'b0;
  bit                 alarm_latched = 1'b0;
  bit                 trip_dir_high = 1'b0;
  logic signed [15:0] trip_val = '0;
  bit                 in_band = 1'b1;
  bit                 flash_ph = 1'b0;
  logic [31:0]        flash_due_at = '0;
  logic [31:0]        chirp_due_at = '0;
  bit                 tone_active = 1'b0;
  bit                 tone_is_chirp = 1'b0;
  logic [2:0]         tone_step = '0;
  logic [31:0]        tone_due_at = '0;
  bit                 tone_level = 1'b0;

  result_t   pending_reports [$];
  plan_row_t plan [$];
  int        fault_count = 0;
  int        cycle_count = 0;
  logic      quiet_tail = 1'b0;
  logic [31:0] clock_ms = '0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic bit reached(logic [31:0] now, logic [31:0] at);
    logic [31:0] gap;
    gap = now - at;
    return !gap[31];
  endfunction

  function automatic logic [31:0] beep_len(int idx);
    return tone_is_chirp ? CHIRP_LEN_MS : BEEP_MS[idx & 7];
  endfunction

  function automatic void start_tone(bit chirp, logic [31:0] now);
    tone_active   = 1'b1;
    tone_is_chirp = chirp;
    tone_step     = '0;
    tone_level    = 1'b1;
    tone_due_at   = now + beep_len(0);
  endfunction

  function automatic result_t alarm_step(func_t f, logic [31:0] now, logic signed [15:0] s);
    event_t  ev;
    bit      over;
    bit      under;
    int      next;
    result_t r;
    ev = EV_NONE;
    if (f == FUNC_DISMISS) begin
      // dismiss does not advance the player or the flash timer
      if (alarm_latched) begin
        alarm_latched = 1'b0;
        flash_ph      = 1'b0;
        tone_active   = 1'b0;
        tone_level    = 1'b0;
        ev            = EV_DISMISSED;
      end
    end else begin
      if (tone_active && reached(now, tone_due_at)) begin
        next = tone_step + 1;
        if (next >= (tone_is_chirp ? 1 : TRIP_BEEPS)) begin
          tone_active = 1'b0;
          tone_level  = 1'b0;
        end else begin
          tone_step   = 3'(next);
          tone_level  = (next % 2 == 0);
          tone_due_at = now + beep_len(next);
        end
      end
      if (alarm_latched) begin
        if (reached(now, flash_due_at)) begin
          flash_due_at = now + FLASH_EVERY_MS;
          flash_ph     = !flash_ph;
        end
        // a due chirp cuts short whatever pattern is playing
        if (reached(now, chirp_due_at)) begin
          chirp_due_at = now + CHIRP_EVERY_MS;
          start_tone(1'b1, now);
        end
      end
      if (f == FUNC_SAMPLE) begin
        over  = hi_arm && (s > hi_thr);
        under = lo_arm && (s < lo_thr);
        if ((over || under) && !alarm_latched) begin
          alarm_latched = 1'b1;
          trip_dir_high = over;
          trip_val      = s;
          in_band       = 1'b0;
          flash_ph      = 1'b1;
          flash_due_at  = now + FLASH_EVERY_MS;
          chirp_due_at  = now + CHIRP_EVERY_MS;
          start_tone(1'b0, now);
          ev = over ? EV_BREACH_HIGH : EV_BREACH_LOW;
        end else if (over || under) begin
          in_band = 1'b0;
        end else if (!in_band) begin
          in_band = 1'b1;
          ev      = EV_BACK_IN_BAND;
        end
      end
    end
    r.latched    = alarm_latched;
    r.trip_high  = trip_dir_high;
    r.trip_value = trip_val;
    r.event_res  = ev;
    r.flash_on   = flash_ph;
    r.buzzer_on  = tone_level;
    return r;
  endfunction

  function automatic result_t outcome(bit l, bit th, logic signed [15:0] tv, event_t ev,
                                      bit fl, bit bz);
    result_t r;
    r.latched    = l;
    r.trip_high  = th;
    r.trip_value = tv;
    r.event_res  = ev;
    r.flash_on   = fl;
    r.buzzer_on  = bz;
    return r;
  endfunction

  function automatic void plan_write(cfg_index_t sel, logic [15:0] value);
    plan_row_t row;
    row.is_write = 1'b1;
    row.reg_sel  = sel;
    row.wdata    = value;
    row.func     = FUNC_TICK;
    row.now_ms   = '0;
    row.sample   = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(func_t f, logic [31:0] t, logic signed [15:0] s,
                                    bit typed = 1'b0, result_t want = '0);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_sel  = CFG_HIGH_THRESHOLD;
    row.wdata    = '0;
    row.func     = f;
    row.now_ms   = t;
    row.sample   = s;
    row.typed    = typed;
    row.want     = want;
    plan.push_back(row);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  task automatic sender_gap();
    item_bus.valid <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  task automatic offer(func_t f, logic [31:0] t, logic signed [15:0] s,
                       bit typed = 1'b0, result_t want = '0);
    result_t predicted;
    item_bus.valid  <= 1'b1;
    item_bus.func   <= f;
    item_bus.now_ms <= t;
    item_bus.sample <= s;
    do @(posedge clk); while (!item_bus.ready);
    predicted = alarm_step(f, t, s);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  // registers change only with nothing in flight
  task automatic program_reg(cfg_index_t sel, logic [15:0] value);
    item_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_HIGH_THRESHOLD: hi_thr = value;
      CFG_LOW_THRESHOLD:  lo_thr = value;
      CFG_HIGH_ENABLE:    hi_arm = value[0];
      CFG_LOW_ENABLE:     lo_arm = value[0];
      default: ;
    endcase
  endtask

  // result side: checks each transaction and throttles ready
  initial begin : result_side
    result_t want;
    int      gap_left;
    int      hold_left;
    int      drained;
    bit      calm;
    gap_left = 0;
    hold_left = 0;
    drained = 0;
    calm = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) begin
        drained++;
        if (pending_reports.size() == 0) begin
          $error("result transaction with nothing pending");
          fault_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("latched", want.latched, result_bus.latched);
          check_field("trip_high", want.trip_high, result_bus.trip_high);
          check_field("trip_value", want.trip_value, result_bus.trip_value);
          check_field("event_res", want.event_res, result_bus.event_res);
          check_field("flash_on", want.flash_on, result_bus.flash_on);
          check_field("buzzer_on", want.buzzer_on, result_bus.buzzer_on);
        end
        if (drained == 150 || drained == 800) hold_left = LONG_HOLD;
        if (drained % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        result_bus.ready <= 1'b0;
      end else if (!quiet_tail && !calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 10) - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : timeout
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    func_t              f;
    logic signed [15:0] s;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    bit                 ha;
    bit                 la;
    bit                 sender_calm;
    bit                 tail;
    int                 r;

    item_bus.valid  = 1'b0;
    item_bus.func   = FUNC_TICK;
    item_bus.now_ms = '0;
    item_bus.sample = '0;

    // disarmed after reset: nothing can trip
    plan_item(FUNC_TICK, 32'd0, 16'sd0, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    plan_item(FUNC_SAMPLE, 32'd1, 16'sh7FFF, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    plan_item(FUNC_SAMPLE, 32'd2, 16'sh8000, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    plan_item(FUNC_DISMISS, 32'd3, 16'sd0, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    plan_item(FUNC_SPARE, 32'd4, -16'sd1, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    // armed at full scale: the extremes stay in band
    plan_write(CFG_HIGH_ENABLE, 16'd1);
    plan_write(CFG_LOW_ENABLE, 16'd1);
    plan_item(FUNC_SAMPLE, 32'd5, 16'sh7FFF, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    plan_item(FUNC_SAMPLE, 32'd6, 16'sh8000, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    plan_write(CFG_HIGH_THRESHOLD, 16'd100);
    plan_write(CFG_LOW_THRESHOLD, -16'sd100);
    // spare code is a plain tick, sample ignored
    plan_item(FUNC_SPARE, 32'd7, 16'sd500, 1'b1, outcome(0, 0, 0, EV_NONE, 0, 0));
    plan_item(FUNC_SAMPLE, 32'd1000, 16'sd101, 1'b1,
              outcome(1, 1, 16'sd101, EV_BREACH_HIGH, 1, 1));
    plan_item(FUNC_TICK, 32'd1070, 16'sd0);
    plan_item(FUNC_SAMPLE, 32'd1100, -16'sd200);
    plan_item(FUNC_SAMPLE, 32'd1130, 16'sd100);
    plan_item(FUNC_TICK, 32'd1250, 16'sd0);
    // long jump: chirp falls due while the trip pattern is still running
    plan_item(FUNC_TICK, 32'd6000, 16'sd0);
    plan_item(FUNC_TICK, 32'd6050, 16'sd0);
    plan_item(FUNC_DISMISS, 32'd6100, 16'sd0, 1'b1,
              outcome(0, 1, 16'sd101, EV_DISMISSED, 0, 0));
    plan_item(FUNC_DISMISS, 32'd6110, 16'sd0, 1'b1, outcome(0, 1, 16'sd101, EV_NONE, 0, 0));
    plan_item(FUNC_SAMPLE, 32'd6200, 16'sh8000, 1'b1,
              outcome(1, 0, 16'sh8000, EV_BREACH_LOW, 1, 1));
    plan_item(FUNC_DISMISS, 32'd6300, 16'sd0, 1'b1,
              outcome(0, 0, 16'sh8000, EV_DISMISSED, 0, 0));
    // still out of band from before the dismiss
    plan_item(FUNC_SAMPLE, 32'd6400, 16'sd0, 1'b1,
              outcome(0, 0, 16'sh8000, EV_BACK_IN_BAND, 0, 0));
    // crossed thresholds: both edges breach, high wins
    plan_write(CFG_HIGH_THRESHOLD, -16'sd100);
    plan_write(CFG_LOW_THRESHOLD, 16'd100);
    plan_item(FUNC_SAMPLE, 32'd6500, 16'sd0, 1'b1, outcome(1, 1, 16'sd0, EV_BREACH_HIGH, 1, 1));
    plan_item(FUNC_DISMISS, 32'd6510, 16'sd0);
    plan_write(CFG_HIGH_THRESHOLD, 16'd100);
    plan_write(CFG_LOW_THRESHOLD, -16'sd100);
    // deadlines wrap past the top of the time stamp
    plan_item(FUNC_SAMPLE, 32'hFFFF_FFC0, 16'sh7FFF, 1'b1,
              outcome(1, 1, 16'sh7FFF, EV_BREACH_HIGH, 1, 1));
    plan_item(FUNC_TICK, 32'h0000_0010, 16'sd0);
    plan_item(FUNC_DISMISS, 32'h0000_0020, 16'sd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        program_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        if ($urandom_range(0, 3) == 0) sender_gap();
        offer(plan[i].func, plan[i].now_ms, plan[i].sample, plan[i].typed, plan[i].want);
      end
    end
    clock_ms = 32'h0000_0020;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          hi = 16'($urandom_range(0, 4000));
          lo = -16'($urandom_range(0, 4000));
          ha = 1'b1;
          la = 1'b1;
        end
        1: begin
          hi = 16'sh7FFE;
          lo = 16'sh8001;
          ha = 1'b1;
          la = 1'b1;
        end
        2: begin
          hi = 16'sh8000;
          lo = 16'sh7FFF;
          ha = 1'b1;
          la = 1'b1;
        end
        3: begin
          hi = 16'($urandom);
          lo = 16'($urandom);
          ha = 1'b1;
          la = 1'b0;
        end
        4: begin
          hi = 16'($urandom);
          lo = 16'($urandom);
          ha = 1'b0;
          la = 1'b1;
        end
        default: begin
          hi = 16'($urandom_range(0, 20000));
          lo = -16'($urandom_range(0, 20000));
          ha = 1'b1;
          la = 1'b1;
        end
      endcase
      program_reg(CFG_HIGH_THRESHOLD, hi);
      program_reg(CFG_LOW_THRESHOLD, lo);
      program_reg(CFG_HIGH_ENABLE, 16'(ha));
      program_reg(CFG_LOW_ENABLE, 16'(la));
      sender_calm = ($urandom_range(0, 2) == 0);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        tail = (phase == PHASES - 1) && (k >= PHASE_ITEMS - TAIL_ITEMS);
        if (tail && !quiet_tail) quiet_tail <= 1'b1;
        // sender pause until the block has drained completely
        if (phase == 2 && k == 100) begin
          item_bus.valid <= 1'b0;
          while (pending_reports.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        if (!tail && !sender_calm && $urandom_range(0, 5) == 0) sender_gap();

        r = $urandom_range(0, 99);
        if (r < 8) f = FUNC_DISMISS;
        else if (r < 11) f = FUNC_SPARE;
        else if (r < 45) f = FUNC_TICK;
        else f = FUNC_SAMPLE;

        r = $urandom_range(0, 99);
        if (r < 70) clock_ms += 32'($urandom_range(0, 120));
        else if (r < 88) clock_ms += 32'($urandom_range(121, 700));
        else if (r < 95) clock_ms += 32'($urandom_range(4000, 6000));
        else if (r < 98) clock_ms = $urandom;
        else clock_ms += 32'h7FFF_FF00 + 32'($urandom_range(0, 511));

        // half the samples around the thresholds so the latch keeps cycling
        r = $urandom_range(0, 99);
        if (r < 25) s = hi_thr - 16'sd3 + 16'($urandom_range(0, 6));
        else if (r < 50) s = lo_thr - 16'sd3 + 16'($urandom_range(0, 6));
        else if (r < 62) begin
          case ($urandom_range(0, 3))
            0: s = 16'sh7FFF;
            1: s = 16'sh8000;
            2: s = 16'sd0;
            default: s = -16'sd1;
          endcase
        end else s = 16'($urandom);

        offer(f, clock_ms, s);
      end
    end

    item_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fault_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
